FILE: rtl/rlsc_pkg.sv
// rlsc_pkg: shared types, character constants and the opcode decode table
// for the rule line syntax checker; no dependencies
package rlsc_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;

    localparam int unsigned OP_COUNT_W = 9;
    localparam logic [OP_COUNT_W-1:0] OP_COUNT_MAX = '1;

    localparam logic [7:0] MAX_OPS_RESET = 8'd255;

    // register indexes on the configuration port
    localparam logic REG_GPU_MODE = 1'b0;
    localparam logic REG_MAX_OPS  = 1'b1;

    typedef struct packed {
        logic       gpu_mode;
        logic [7:0] max_ops;
    } cfg_t;

    // known opcode, refused in gpu mode, argument count, position mask
    typedef struct packed {
        logic       known;
        logic       gpu;
        logic [1:0] nargs;
        logic [2:0] pos;
    } dec_t;

    function automatic dec_t decode_op(input logic [7:0] c);
        dec_t d;
        d = '0;
        case (c)
            ":", "l", "u", "c", "C", "t", "r", "d", "f", "{", "}", "[",
            "]", "a", "q", "k", "K", "E":
                d = '{known: 1'b1, gpu: 1'b0, nargs: 2'd0, pos: 3'b000};
            "T", "p", "D", "'", "z", "Z", "y", "Y", "L", "R", "+", "-",
            ".", ",":
                d = '{known: 1'b1, gpu: 1'b0, nargs: 2'd1, pos: 3'b001};
            "$", "^", "@":
                d = '{known: 1'b1, gpu: 1'b0, nargs: 2'd1, pos: 3'b000};
            "x", "*":
                d = '{known: 1'b1, gpu: 1'b0, nargs: 2'd2, pos: 3'b011};
            "i", "o":
                d = '{known: 1'b1, gpu: 1'b0, nargs: 2'd2, pos: 3'b001};
            "s":
                d = '{known: 1'b1, gpu: 1'b0, nargs: 2'd2, pos: 3'b000};
            "X":
                d = '{known: 1'b1, gpu: 1'b1, nargs: 2'd3, pos: 3'b111};
            "4", "6", "M", "Q":
                d = '{known: 1'b1, gpu: 1'b1, nargs: 2'd0, pos: 3'b000};
            "<", ">":
                d = '{known: 1'b1, gpu: 1'b1, nargs: 2'd1, pos: 3'b001};
            "!", "/", "(", ")":
                d = '{known: 1'b1, gpu: 1'b1, nargs: 2'd1, pos: 3'b000};
            "=", "%":
                d = '{known: 1'b1, gpu: 1'b1, nargs: 2'd2, pos: 3'b001};
            default:
                d = '0;
        endcase
        return d;
    endfunction

    function automatic logic is_position(input logic [7:0] c);
        return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_A) && (c <= CH_Z));
    endfunction

endpackage

FILE: rtl/rlsc_cfg_regs.sv
// rlsc_cfg_regs: apb-style configuration registers (gpu_mode, max_ops)
// depends on rlsc_pkg
module rlsc_cfg_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output rlsc_pkg::cfg_t      cfg
);

    logic       gpu_mode_reg;
    logic [7:0] max_ops_reg;
    logic       wr_en;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gpu_mode_reg <= 1'b0;
            max_ops_reg  <= rlsc_pkg::MAX_OPS_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                rlsc_pkg::REG_GPU_MODE: gpu_mode_reg <= pwdata[0];
                rlsc_pkg::REG_MAX_OPS:  max_ops_reg  <= pwdata[7:0];
                default:                gpu_mode_reg <= gpu_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            rlsc_pkg::REG_GPU_MODE: prdata = {31'd0, gpu_mode_reg};
            rlsc_pkg::REG_MAX_OPS:  prdata = {24'd0, max_ops_reg};
            default:                prdata = 32'd0;
        endcase
    end

    assign cfg.gpu_mode = gpu_mode_reg;
    assign cfg.max_ops  = max_ops_reg;

endmodule

FILE: rtl/rlsc_line_state.sv
// rlsc_line_state: per-line parse state and its update from a
// registered item; depends on rlsc_pkg
module rlsc_line_state
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          char_code,
    input  logic                has_char,
    input  logic                last,
    input  rlsc_pkg::cfg_t      cfg,
    output logic                line_ok
);

    localparam int unsigned CW = rlsc_pkg::OP_COUNT_W;

    logic          pend_reg,    pend_next,    pend_b;
    logic [2:0]    pos_reg,     pos_next,     pos_b;
    logic [1:0]    nargs_reg,   nargs_next,   nargs_b;
    logic [1:0]    arg_idx_reg, arg_idx_next, arg_idx_b;
    logic [CW-1:0] cnt_reg,     cnt_next,     cnt_b;
    logic          rej_reg,     rej_next,     rej_b;
    rlsc_pkg::dec_t dec;
    logic          pos_ok;

    always_comb
    begin
        dec       = rlsc_pkg::decode_op(char_code);
        pos_ok    = rlsc_pkg::is_position(char_code);
        pend_b    = pend_reg;
        pos_b     = pos_reg;
        nargs_b   = nargs_reg;
        arg_idx_b = arg_idx_reg;
        cnt_b     = cnt_reg;
        rej_b     = rej_reg;

        if (has_char && !rej_reg)
        begin
            if (pend_reg)
            begin
                // argument byte of the pending opcode
                if (pos_reg[arg_idx_reg] && !pos_ok)
                begin
                    rej_b = 1'b1;
                end
                else
                begin
                    arg_idx_b = arg_idx_reg + 2'd1;
                    if (arg_idx_b >= nargs_reg)
                    begin
                        pend_b    = 1'b0;
                        arg_idx_b = 2'd0;
                    end
                end
            end
            else if (char_code != rlsc_pkg::CH_SPACE)
            begin
                if (!dec.known || (dec.gpu && cfg.gpu_mode))
                begin
                    rej_b = 1'b1;
                end
                else
                begin
                    if (cnt_reg != rlsc_pkg::OP_COUNT_MAX)
                    begin
                        cnt_b = cnt_reg + {{(CW-1){1'b0}}, 1'b1};
                    end
                    if (cnt_b > {{(CW-8){1'b0}}, cfg.max_ops})
                    begin
                        rej_b = 1'b1;
                    end
                    else if (dec.nargs != 2'd0)
                    begin
                        pend_b    = 1'b1;
                        pos_b     = dec.pos;
                        nargs_b   = dec.nargs;
                        arg_idx_b = 2'd0;
                    end
                end
            end
        end

        line_ok = !rej_b && !pend_b;

        // end of line returns the pending flag, argument index, count and reject flag to idle
        if (last)
        begin
            pend_next    = 1'b0;
            arg_idx_next = 2'd0;
            cnt_next     = '0;
            rej_next     = 1'b0;
        end
        else
        begin
            pend_next    = pend_b;
            arg_idx_next = arg_idx_b;
            cnt_next     = cnt_b;
            rej_next     = rej_b;
        end
        pos_next   = pos_b;
        nargs_next = nargs_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= 1'b0;
            arg_idx_reg <= 2'd0;
            cnt_reg     <= '0;
            rej_reg     <= 1'b0;
        end
        else if (take)
        begin
            pend_reg    <= pend_next;
            arg_idx_reg <= arg_idx_next;
            cnt_reg     <= cnt_next;
            rej_reg     <= rej_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pos_reg   <= pos_next;
            nargs_reg <= nargs_next;
        end
    end

    // a pending opcode never has all its arguments already taken
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (arg_idx_reg < nargs_reg))
        else $error("argument index past argument count");

    // the pending, reject and count state are clear after the closing item
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && last) |=> (!pend_reg && !rej_reg && (cnt_reg == '0)))
        else $error("state not cleared at end of line");

endmodule

FILE: rtl/rule_line_syntax_checker_unit.sv
// rule_line_syntax_checker_unit: top level of the rule line syntax checker
// depends on rlsc_pkg, rlsc_cfg_regs and rlsc_line_state
//
//  channel   signals                                     direction  moves
//  item      item_valid item_ready char_code has_char last   in     one byte
//  result    result_valid result_ready line_ok             out    one verdict
//  config    psel penable pwrite paddr pwdata prdata pready  in/out  registers
//
// one item a cycle unless a closing item waits on a held verdict; items pass
// the input register, then the parse-state update feeding the result register
// rst_n clears the line state, the holding registers' valid flags and the
// configuration (gpu_mode 0, max_ops 255)
// a stalled result only holds up an item that closes a line and those behind it;
// other items keep flowing through the input register while the verdict waits
module rule_line_syntax_checker_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // item channel
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [7:0]  char_code,
    input  logic        has_char,
    input  logic        last,
    // result channel
    output logic        result_valid,
    input  logic        result_ready,
    output logic        line_ok
);

    rlsc_pkg::cfg_t cfg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_has_reg;
    logic       in_last_reg;

    // result register
    logic       res_valid_reg, res_valid_next;
    logic       res_ok_reg;

    logic       in_take;     // registered item moves into the parse state
    logic       res_free;    // result register can take a verdict this cycle
    logic       verdict_ok;

    rlsc_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // an item with no verdict always moves on; a closing item needs room
    assign res_free   = !res_valid_reg || result_ready;
    assign in_take    = in_valid_reg && (!in_last_reg || res_free);
    assign item_ready = !in_valid_reg || in_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            in_char_reg <= char_code;
            in_has_reg  <= has_char;
            in_last_reg <= last;
        end
    end

    rlsc_line_state u_line
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (in_take),
        .char_code (in_char_reg),
        .has_char  (in_has_reg),
        .last      (in_last_reg),
        .cfg       (cfg),
        .line_ok   (verdict_ok)
    );

    always_comb
    begin
        res_valid_next = res_valid_reg && !result_ready;
        if (in_take && in_last_reg)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take && in_last_reg)
        begin
            res_ok_reg <= verdict_ok;
        end
    end

    assign result_valid = res_valid_reg;
    assign line_ok      = res_ok_reg;

    // a new verdict only follows a closing item leaving the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(in_valid_reg && in_last_reg))
        else $error("verdict without a closing item");

    // the input side only stalls behind a held closing item and a held verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> (in_valid_reg && in_last_reg && res_valid_reg && !result_ready))
        else $error("input stalled without cause");

    // a closing item never overwrites a verdict that has not been taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && in_last_reg) |-> (!res_valid_reg || result_ready))
        else $error("verdict overwritten");

endmodule
